// ----- rtl/core/pulse_rate_detector_core_macros.svh -----
// ----------------------------------------------------------------------------
// pulse_rate_detector_core_macros
// assertion helpers shared by the pulse rate detector rtl
// ----------------------------------------------------------------------------
`ifndef PULSE_RATE_DETECTOR_CORE_MACROS_SVH
`define PULSE_RATE_DETECTOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
// plain property, checked on clk outside reset
`define PRD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// overlapping implication, checked on clk outside reset
`define PRD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define PRD_ASSERT(label, prop, msg)
`define PRD_ASSERT_IMP(label, ante, cons, msg)
`endif
`endif

// ----- rtl/core/prd_pkg.sv -----
// ----------------------------------------------------------------------------
// prd_pkg
// widths, constants, register codes and shared types of the rate detector
// ----------------------------------------------------------------------------
`default_nettype none
package prd_pkg;

  // ring and fixed point
  localparam int WINDOW     = 128;
  localparam int PTR_W      = $clog2(WINDOW);
  localparam int FRAC_BITS  = 6;
  localparam int SAMPLE_W   = 10;
  localparam int FILT_W     = SAMPLE_W + FRAC_BITS;
  localparam int SUM_W      = FILT_W + PTR_W;
  localparam int THR_W      = 17;

  // rate arithmetic
  localparam int RATE_W     = 13;
  localparam int TIME_W     = 16;
  localparam int NUM_W      = 20;
  localparam int CNT_W      = $clog2(NUM_W + 1);
  localparam logic [RATE_W-1:0] RATE_MAX   = RATE_W'(4800);
  localparam logic [NUM_W-1:0]  RATE_NUM   = NUM_W'(960000);
  localparam logic [TIME_W-1:0] TIME_MAX   = TIME_W'(65535);
  localparam logic [FILT_W-1:0] FILT_RESET = FILT_W'(520 << FRAC_BITS);

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA      = 3'd0,
    REG_OFFSET     = 3'd1,
    REG_MIN_INT    = 3'd2,
    REG_MAX_INT    = 3'd3,
    REG_MAX_CHANGE = 3'd4,
    REG_PERIOD     = 3'd5
  } reg_idx_t;

  // sequencer
  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_FILT = 7'b0000010,
    ST_RING = 7'b0000100,
    ST_THR  = 7'b0001000,
    ST_DIV  = 7'b0010000,
    ST_DEC  = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

  // divider handshake
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage
`default_nettype wire

// ----- rtl/core/prd_ring_ram.sv -----
// ----------------------------------------------------------------------------
// prd_ring_ram
// single port window memory, registered read data
// ----------------------------------------------------------------------------
`default_nettype none
module prd_ring_ram (
  input  wire logic                       clk,
  input  wire logic                       rd_en,
  input  wire logic                       wr_en,
  input  wire logic [prd_pkg::PTR_W-1:0]  addr,
  input  wire logic [prd_pkg::FILT_W-1:0] wdata,
  output logic      [prd_pkg::FILT_W-1:0] rdata
);

  logic [prd_pkg::FILT_W-1:0] mem [prd_pkg::WINDOW];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/prd_divider.sv -----
// ----------------------------------------------------------------------------
// prd_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module prd_divider (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire prd_pkg::div_ctl_t          ctl,
  input  wire logic [prd_pkg::NUM_W-1:0]  num,
  input  wire logic [prd_pkg::TIME_W-1:0] den,
  output prd_pkg::div_sts_t               sts,
  output logic      [prd_pkg::NUM_W-1:0]  quo
);

  logic [prd_pkg::TIME_W:0]   rem_r;
  logic [prd_pkg::NUM_W-1:0]  quo_r;
  logic [prd_pkg::TIME_W-1:0] den_r;
  logic [prd_pkg::CNT_W-1:0]  cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic [prd_pkg::TIME_W:0]   trial;
  logic                       fits;

  // one trial subtraction
  always_comb begin
    trial = {rem_r[prd_pkg::TIME_W-1:0], quo_r[prd_pkg::NUM_W-1]};
    fits  = trial >= {1'b0, den_r};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= prd_pkg::CNT_W'(prd_pkg::NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == prd_pkg::CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= fits ? trial - {1'b0, den_r} : trial;
      quo_r <= {quo_r[prd_pkg::NUM_W-2:0], fits};
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quo      = quo_r;

endmodule
`default_nettype wire

// ----- rtl/core/pulse_rate_detector_core.sv -----
// ----------------------------------------------------------------------------
// pulse_rate_detector_core
// heart rate peak detector with an adaptive threshold over a sample window
// ----------------------------------------------------------------------------
// Usage:
//  in_* carries one 10-bit sensor sample per item; out_* returns exactly one
//  result item per sample (rates in 1/16 BPM, flags, threshold in Q6).
//  cfg_wr_en writes register cfg_index with cfg_data in the same cycle;
//  write only while no sample is in flight.
//  An item without a pulse passes the filter, window, threshold, decision and
//  done steps before out_valid; a pulse adds a pass through the serial divider
//  (a 20-bit quotient) between threshold and decision. The sequencer returns
//  to idle as the result enters the output register, so a new sample is
//  accepted only after the previous one has been handed off there.
//  The result sits in an output register: a stalled receiver does not stop
//  the next item from being accepted and processed, only its hand-off.
//  Reset loads the default registers and resets the rate state, the lowest
//  rate to RATE_MAX; the window memory needs no clearing pass, its entries
//  count as zero until the ring has wrapped once.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pulse_rate_detector_core_macros.svh"
module pulse_rate_detector_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [prd_pkg::SAMPLE_W-1:0]   in_sample,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [prd_pkg::RATE_W-1:0]     out_current_rate,
  output logic      [prd_pkg::RATE_W-1:0]     out_lowest_rate,
  output logic      [prd_pkg::RATE_W-1:0]     out_highest_rate,
  output logic                                out_pulse_accepted,
  output logic                                out_pulse_rejected,
  output logic                                out_rate_valid,
  output logic                                out_timed_out,
  output logic      [prd_pkg::THR_W-1:0]      out_threshold_level,
  input  wire logic                           cfg_wr_en,
  input  wire logic [prd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [prd_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int FW = prd_pkg::FILT_W;
  localparam int RW = prd_pkg::RATE_W;
  localparam int TW = prd_pkg::TIME_W;

  // configuration registers
  logic [8:0]  alpha_r;
  logic [7:0]  offset_r;
  logic [TW-1:0] min_int_r;
  logic [TW-1:0] max_int_r;
  logic [RW-1:0] max_change_r;
  logic [9:0]  period_r;

  // state
  prd_pkg::state_t state_r, state_nxt;
  logic [prd_pkg::SAMPLE_W-1:0] sample_r;
  logic [FW-1:0]               fv_r, fv_nxt;
  logic [prd_pkg::PTR_W-1:0]   ptr_r;
  logic                        wrapped_r;
  logic [prd_pkg::SUM_W-1:0]   sum_r, sum_nxt;
  logic [prd_pkg::THR_W-1:0]   thr_r, thr_nxt;
  logic                        pulse_r;
  logic [TW-1:0]               since_r, since_nxt;
  logic [RW-1:0]               rate_now_r, rate_now_nxt;
  logic [RW-1:0]               last_good_r, last_good_nxt;
  logic [RW-1:0]               rate_low_r, rate_low_nxt;
  logic [RW-1:0]               rate_high_r, rate_high_nxt;
  logic                        seen_r, seen_nxt;
  logic                        acc_r, acc_nxt;
  logic                        rej_r, rej_nxt;
  logic                        tout_r, tout_nxt;
  logic                        out_valid_r;
  logic                        slot_free;

  // memory and divider hookup
  logic [FW-1:0]               ram_rdata;
  logic [FW-1:0]               old_entry;
  prd_pkg::div_ctl_t           div_ctl;
  prd_pkg::div_sts_t           div_sts;
  logic [prd_pkg::NUM_W-1:0]   div_num;
  logic [prd_pkg::NUM_W-1:0]   div_quo;
  logic [prd_pkg::NUM_W-1:0]   quo_r;

  // combinational helpers
  logic [8:0]                  alpha_sat;
  logic [FW-1:0]               raw_q;
  logic [24:0]                 prod_new, prod_old;
  logic [25:0]                 filt_sum;
  logic                        pulse_now;
  logic [RW-1:0]               rate_sat;
  logic [RW-1:0]               rate_diff;
  logic [TW-1:0]               since_a, since_b;
  logic [TW:0]                 since_add;

  assign in_ready  = (state_r == prd_pkg::ST_IDLE);
  assign slot_free = !out_valid_r || out_ready;
  assign raw_q     = {sample_r, prd_pkg::FRAC_BITS'(0)};
  assign old_entry = wrapped_r ? ram_rdata : '0;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r      <= 9'd51;
      offset_r     <= 8'd1;
      min_int_r    <= TW'(300);
      max_int_r    <= TW'(2000);
      max_change_r <= RW'(320);
      period_r     <= 10'd50;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        prd_pkg::REG_ALPHA:      alpha_r      <= cfg_data[8:0];
        prd_pkg::REG_OFFSET:     offset_r     <= cfg_data[7:0];
        prd_pkg::REG_MIN_INT:    min_int_r    <= cfg_data;
        prd_pkg::REG_MAX_INT:    max_int_r    <= cfg_data;
        prd_pkg::REG_MAX_CHANGE: max_change_r <= cfg_data[RW-1:0];
        prd_pkg::REG_PERIOD:     period_r     <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  // low-pass filter
  always_comb begin
    alpha_sat = (alpha_r > 9'd256) ? 9'd256 : alpha_r;
    prod_new  = alpha_sat * raw_q;
    prod_old  = (9'd256 - alpha_sat) * fv_r;
    filt_sum  = {1'b0, prod_new} + {1'b0, prod_old} + 26'd128;
    fv_nxt    = filt_sum[FW+7:8];
  end

  // window sum, threshold, pulse test and divider numerator
  always_comb begin
    sum_nxt = sum_r - prd_pkg::SUM_W'(old_entry) + prd_pkg::SUM_W'(fv_r);
    thr_nxt = prd_pkg::THR_W'(sum_r >> prd_pkg::PTR_W)
            + prd_pkg::THR_W'({offset_r, prd_pkg::FRAC_BITS'(0)});
    pulse_now = (prd_pkg::THR_W'(raw_q) > thr_nxt) && (since_r > min_int_r)
              && (since_r != '0);
    div_num = prd_pkg::RATE_NUM + prd_pkg::NUM_W'(since_r >> 1);
  end

  // pulse decision, timeout and elapsed time
  always_comb begin
    rate_sat      = (quo_r > prd_pkg::NUM_W'(prd_pkg::RATE_MAX)) ? prd_pkg::RATE_MAX
                                                                 : quo_r[RW-1:0];
    rate_diff     = (rate_sat > last_good_r) ? rate_sat - last_good_r
                                             : last_good_r - rate_sat;
    rej_nxt       = pulse_r && seen_r && (rate_diff > max_change_r);
    acc_nxt       = pulse_r && !rej_nxt;
    rate_now_nxt  = acc_nxt ? rate_sat : rate_now_r;
    last_good_nxt = acc_nxt ? rate_sat : last_good_r;
    rate_low_nxt  = (acc_nxt && rate_sat < rate_low_r) ? rate_sat : rate_low_r;
    rate_high_nxt = (acc_nxt && rate_sat > rate_high_r) ? rate_sat : rate_high_r;
    seen_nxt      = acc_nxt ? 1'b1 : seen_r;
    since_a       = acc_nxt ? '0 : since_r;
    tout_nxt      = since_a > max_int_r;
    if (tout_nxt) begin
      rate_now_nxt = '0;
      seen_nxt     = 1'b0;
    end
    since_b   = tout_nxt ? '0 : since_a;
    since_add = {1'b0, since_b} + (TW + 1)'(period_r);
    since_nxt = since_add[TW] ? prd_pkg::TIME_MAX : since_add[TW-1:0];
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    div_ctl.start = 1'b0;
    case (state_r)
      prd_pkg::ST_IDLE: if (in_valid) state_nxt = prd_pkg::ST_FILT;
      prd_pkg::ST_FILT: state_nxt = prd_pkg::ST_RING;
      prd_pkg::ST_RING: state_nxt = prd_pkg::ST_THR;
      prd_pkg::ST_THR: begin
        div_ctl.start = pulse_now;
        state_nxt     = pulse_now ? prd_pkg::ST_DIV : prd_pkg::ST_DEC;
      end
      prd_pkg::ST_DIV:  if (div_sts.done) state_nxt = prd_pkg::ST_DEC;
      prd_pkg::ST_DEC:  state_nxt = prd_pkg::ST_DONE;
      prd_pkg::ST_DONE: if (slot_free) state_nxt = prd_pkg::ST_IDLE;
      default:          state_nxt = prd_pkg::ST_IDLE;
    endcase
  end

  // control and rate state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= prd_pkg::ST_IDLE;
      fv_r        <= prd_pkg::FILT_RESET;
      ptr_r       <= '0;
      wrapped_r   <= 1'b0;
      sum_r       <= '0;
      since_r     <= '0;
      rate_now_r  <= '0;
      last_good_r <= '0;
      rate_low_r  <= prd_pkg::RATE_MAX;
      rate_high_r <= '0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == prd_pkg::ST_FILT) begin
        fv_r <= fv_nxt;
      end
      if (state_r == prd_pkg::ST_RING) begin
        sum_r <= sum_nxt;
        ptr_r <= ptr_r + 1'b1;
        if (ptr_r == prd_pkg::PTR_W'(prd_pkg::WINDOW - 1)) begin
          wrapped_r <= 1'b1;
        end
      end
      if (state_r == prd_pkg::ST_DEC) begin
        since_r     <= since_nxt;
        rate_now_r  <= rate_now_nxt;
        last_good_r <= last_good_nxt;
        rate_low_r  <= rate_low_nxt;
        rate_high_r <= rate_high_nxt;
        seen_r      <= seen_nxt;
      end
      if (state_r == prd_pkg::ST_DONE && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // per-item payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sample_r <= in_sample;
    end
    if (state_r == prd_pkg::ST_THR) begin
      thr_r   <= thr_nxt;
      pulse_r <= pulse_now;
    end
    if (state_r == prd_pkg::ST_DIV && div_sts.done) begin
      quo_r <= div_quo;
    end
    if (state_r == prd_pkg::ST_DEC) begin
      acc_r  <= acc_nxt;
      rej_r  <= rej_nxt;
      tout_r <= tout_nxt;
    end
    if (state_r == prd_pkg::ST_DONE && slot_free) begin
      out_current_rate    <= rate_now_r;
      out_lowest_rate     <= rate_low_r;
      out_highest_rate    <= rate_high_r;
      out_pulse_accepted  <= acc_r;
      out_pulse_rejected  <= rej_r;
      out_rate_valid      <= seen_r;
      out_timed_out       <= tout_r;
      out_threshold_level <= thr_r;
    end
  end

  assign out_valid = out_valid_r;

  // window memory
  prd_ring_ram u_ring (
    .clk   (clk),
    .rd_en (state_r == prd_pkg::ST_FILT),
    .wr_en (state_r == prd_pkg::ST_RING),
    .addr  (ptr_r),
    .wdata (fv_r),
    .rdata (ram_rdata)
  );

  // interval divider
  prd_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (div_ctl),
    .num   (div_num),
    .den   (since_r),
    .sts   (div_sts),
    .quo   (div_quo)
  );

  // checks
  `PRD_ASSERT_IMP(a_accept_starts, in_valid && in_ready, ##1 !in_ready,
                  "item accepted but sequencer stayed idle")
  `PRD_ASSERT_IMP(a_div_done_state, div_sts.done, state_r == prd_pkg::ST_DIV,
                  "divider finished outside the divide step")
  `PRD_ASSERT_IMP(a_out_from_done, $rose(out_valid_r), $past(state_r) == prd_pkg::ST_DONE,
                  "result raised without a finished item")
  `PRD_ASSERT(a_rate_range, rate_now_r <= prd_pkg::RATE_MAX && rate_high_r <= prd_pkg::RATE_MAX,
              "rate above the saturation limit")
  `PRD_ASSERT_IMP(a_flags_excl, out_valid_r, !(out_pulse_accepted && out_pulse_rejected),
                  "pulse both accepted and rejected")

endmodule
`default_nettype wire
